// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] a_num;
		logic [30:0] a_den;
		logic [31:0] b_num;
		logic [30:0] b_den;
	} rau_in_t;

	typedef struct packed {
		logic [31:0] res_num;
		logic [30:0] res_den;
		logic        equal;
		logic [1:0]  status;
	} rau_out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DONE
	} rau_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic comb;
		logic gcd_step;
		logic div_init_n;
		logic div_init_d;
		logic div_step;
		logic div_take_n;
		logic fin;
	} rau_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic n_zero;
		logic gcd_done;
		logic div_last;
	} rau_sts_t;

endpackage

// ===== rtl/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Reduced-fraction add, subtract, multiply and divide with status.
// ----------------------------------------------------------------------------
// One word at a time: raise start while busy is low. After the accepting cycle
// come the multiply, second multiply and combine steps, a binary gcd loop, two
// restoring divisions on the shared divider and a final step that forms the
// result; a new word is taken only once busy is low again. A bad operand or a
// zero numerator skips the gcd and the divisions. The result shows for one
// cycle with done, while busy is already low, and cannot be stalled.
module rational_arithmetic_unit_top import rau_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rau_in_t  in_word,
	output logic     busy,
	output logic     done,
	output rau_out_t out_word
);

	rau_cmd_t cmd;
	rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	rau_dp #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .in_word(in_word), .cmd(cmd), .sts(sts), .out_word(out_word)
	);

endmodule

// ===== rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply, combine, gcd loop, two exact divisions, result.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  rau_sts_t   sts,
	output rau_cmd_t   cmd,
	output logic       busy,
	output logic       done
);

	rau_state_t state_q, state_d;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_DONE);
		end
	end

	assign done = done_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				state_d = S_GCD;
			end
			S_GCD: begin
				if (sts.bad || sts.n_zero) state_d = S_DONE;
				else if (sts.gcd_done) begin
					cmd.div_init_n = 1'b1;
					state_d = S_DIVN;
				end else cmd.gcd_step = 1'b1;
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.div_take_n = 1'b1;
					cmd.div_init_d = 1'b1;
					state_d = S_DIVD;
				end
			end
			S_DIVD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_DONE;
			end
			S_DONE: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: cross products, binary gcd, restoring divider, range check.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic     clk,
	input  rau_in_t  in_word,
	input  rau_cmd_t cmd,
	output rau_sts_t sts,
	output rau_out_t out_word
);

	logic [1:0]  func_q;
	logic        an_neg_q, bn_neg_q;
	logic [31:0] an_q, bn_q;
	logic [30:0] ad_q, bd_q;
	logic        bad_q, equal_q;
	logic [61:0] p1_q, p3_q;
	logic [62:0] p2_q;
	logic [62:0] n_q, d_q;
	logic        rneg_q;
	logic [62:0] gx_q, gy_q;
	logic [5:0]  gk_q;
	logic [62:0] dv_q, quo_q, rem_q, qn_q;
	logic [5:0]  dc_q;
	rau_out_t    out_q;

	logic [31:0] an_mag, bn_mag;
	logic [61:0] m_a, m_b;
	logic [62:0] g_div, gx_n, gy_n;
	logic [63:0] rem_sh;
	logic [62:0] lim;
	logic        s1, s2, ovf;
	logic [62:0] nr;

	assign an_mag = in_word.a_num[31] ? (~in_word.a_num + 32'd1) : in_word.a_num;
	assign bn_mag = in_word.b_num[31] ? (~in_word.b_num + 32'd1) : in_word.b_num;

	always_comb begin
		m_a = {30'd0, an_q};
		m_b = {31'd0, bd_q};
		if (cmd.mul2) begin
			unique case (func_q)
				FUNC_MUL: begin m_a = {30'd0, an_q}; m_b = {30'd0, bn_q}; end
				FUNC_DIV: begin m_a = {31'd0, ad_q}; m_b = {30'd0, bn_q}; end
				default:  begin m_a = {30'd0, bn_q}; m_b = {31'd0, ad_q}; end
			endcase
		end
	end

	assign s1 = an_neg_q && (p1_q != '0);
	assign s2 = (bn_neg_q != (func_q == FUNC_SUB)) && (p2_q != '0);

	always_comb begin
		gx_n = gx_q;
		gy_n = gy_q;
		if (!gx_q[0] && !gy_q[0]) begin
			gx_n = gx_q >> 1;
			gy_n = gy_q >> 1;
		end else if (!gx_q[0]) gx_n = gx_q >> 1;
		else if (!gy_q[0]) gy_n = gy_q >> 1;
		else if (gx_q >= gy_q) gx_n = (gx_q - gy_q) >> 1;
		else gy_n = (gy_q - gx_q) >> 1;
	end

	assign g_div = gx_q << gk_q;
	assign rem_sh = {rem_q, quo_q[62]};
	assign lim = 63'd1 << (WIDTH - 1);
	assign nr = rneg_q ? (63'd0 - qn_q) : qn_q;
	assign ovf = (quo_q >= lim) || (rneg_q ? (qn_q > lim) : (qn_q >= lim));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_word.func;
			an_neg_q <= in_word.a_num[31];
			bn_neg_q <= in_word.b_num[31];
			an_q     <= an_mag;
			bn_q     <= bn_mag;
			ad_q     <= in_word.a_den;
			bd_q     <= in_word.b_den;
			equal_q  <= (in_word.a_num == in_word.b_num) && (in_word.a_den == in_word.b_den);
			bad_q    <= (in_word.a_den == '0) || (in_word.b_den == '0) ||
				(in_word.func == FUNC_DIV && in_word.b_num == '0);
		end
		if (cmd.mul1) p1_q <= m_a[31:0] * m_b[31:0];
		if (cmd.mul2) p2_q <= m_a[31:0] * m_b[31:0];
		if (cmd.mul2) p3_q <= {31'd0, ad_q} * {31'd0, bd_q};
		if (cmd.comb) begin
			unique case (func_q)
				FUNC_MUL: begin
					n_q <= p2_q; d_q <= {1'b0, p3_q}; rneg_q <= an_neg_q != bn_neg_q;
				end
				FUNC_DIV: begin
					n_q <= {1'b0, p1_q}; d_q <= p2_q; rneg_q <= an_neg_q != bn_neg_q;
				end
				default: begin
					d_q <= {1'b0, p3_q};
					if (s1 == s2) begin
						n_q <= {1'b0, p1_q} + p2_q; rneg_q <= s1;
					end else if ({1'b0, p1_q} >= p2_q) begin
						n_q <= {1'b0, p1_q} - p2_q; rneg_q <= s1;
					end else begin
						n_q <= p2_q - {1'b0, p1_q}; rneg_q <= s2;
					end
				end
			endcase
			gk_q <= '0;
		end
		if (cmd.comb) begin
			unique case (func_q)
				FUNC_MUL: begin gx_q <= p2_q; gy_q <= {1'b0, p3_q}; end
				FUNC_DIV: begin gx_q <= {1'b0, p1_q}; gy_q <= p2_q; end
				default: begin
					gy_q <= {1'b0, p3_q};
					if (s1 == s2) gx_q <= {1'b0, p1_q} + p2_q;
					else if ({1'b0, p1_q} >= p2_q) gx_q <= {1'b0, p1_q} - p2_q;
					else gx_q <= p2_q - {1'b0, p1_q};
				end
			endcase
		end else if (cmd.gcd_step) begin
			gx_q <= gx_n;
			gy_q <= gy_n;
			if (!gx_q[0] && !gy_q[0]) gk_q <= gk_q + 6'd1;
		end
		if (cmd.div_init_n) begin
			dv_q <= g_div; quo_q <= n_q; rem_q <= '0; dc_q <= '0;
		end else if (cmd.div_init_d) begin
			dv_q <= dv_q; quo_q <= d_q; rem_q <= '0; dc_q <= '0;
		end else if (cmd.div_step) begin
			dc_q <= dc_q + 6'd1;
			if (rem_sh >= {1'b0, dv_q}) begin
				rem_q <= 63'(rem_sh - {1'b0, dv_q}); quo_q <= {quo_q[61:0], 1'b1};
			end else begin
				rem_q <= rem_sh[62:0]; quo_q <= {quo_q[61:0], 1'b0};
			end
		end
		if (cmd.div_take_n) qn_q <= (rem_sh >= {1'b0, dv_q}) ?
			{quo_q[61:0], 1'b1} : {quo_q[61:0], 1'b0};
		if (cmd.fin) begin
			out_q.equal <= equal_q;
			if (bad_q) begin
				out_q.status <= ST_DIVZ; out_q.res_num <= '0; out_q.res_den <= '0;
			end else if (n_q == '0) begin
				out_q.status <= ST_OK; out_q.res_num <= '0; out_q.res_den <= 31'd1;
			end else if (ovf) begin
				out_q.status <= ST_OVF; out_q.res_num <= '0; out_q.res_den <= '0;
			end else begin
				out_q.status <= ST_OK; out_q.res_num <= nr[31:0]; out_q.res_den <= quo_q[30:0];
			end
		end
	end

	assign sts.bad      = bad_q;
	assign sts.n_zero   = (n_q == '0);
	assign sts.gcd_done = (gx_q == gy_q) || (gy_q == '0) || (gx_q == '0);
	assign sts.div_last = (dc_q == 6'd62);
	assign out_word     = out_q;

endmodule
